@@ sv/cam_block_command_router_macros.svh @@
// ----------------------------------------------------------------------------
// command router assertion macros
// shared concurrent assertion forms, reset-qualified, reporting by $error
// ----------------------------------------------------------------------------
`ifndef CAM_BLOCK_COMMAND_ROUTER_MACROS_SVH
`define CAM_BLOCK_COMMAND_ROUTER_MACROS_SVH

// same-cycle implication
`define CBCR_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/cbcr_pkg.sv @@
// ----------------------------------------------------------------------------
// command router package
// item types, opcodes and fixed sizes shared by the router files
// ----------------------------------------------------------------------------
`default_nettype none

package cbcr_pkg;

  localparam int unsigned WORD_W        = 64;
  localparam int unsigned LINE_W        = 512;
  localparam int unsigned LANE_W        = 32;
  localparam int unsigned LANES         = 16;
  localparam int unsigned DEST_W        = 16;
  localparam int unsigned BLOCK_ROWS    = 128;
  localparam int unsigned ROW_BITS      = $clog2(BLOCK_ROWS);
  localparam int unsigned WORDS_PER_BLK = BLOCK_ROWS / 16;
  localparam int unsigned WL_W          = $clog2(WORDS_PER_BLK + 1);
  localparam int unsigned PTR_W         = 5;
  localparam int unsigned FIFO_DEPTH    = 4;
  localparam int unsigned FIFO_PTR_W    = $clog2(FIFO_DEPTH);
  localparam int unsigned FIFO_CNT_W    = $clog2(FIFO_DEPTH + 1);

  localparam logic [31:0] OP_NOP          = 32'hffffff00;
  localparam logic [31:0] OP_UPDATE_ALL   = 32'hffffff01;
  localparam logic [31:0] OP_UPDATE_ONE   = 32'hffffff02;
  localparam logic [31:0] OP_SEARCH_ONE   = 32'hffffff03;
  localparam logic [31:0] OP_SEARCH_MQ    = 32'hffffff04;
  localparam logic [31:0] OP_UPDATE_GROUP = 32'hffffff06;
  localparam logic [31:0] LANE_NONE       = 32'hffffffff;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_TABLE,
    MODE_ALL,
    MODE_GROUP,
    MODE_MQ
  } mode_e;

  typedef struct packed {
    logic [WORD_W-1:0] word0;
    logic [WORD_W-1:0] word1;
    logic [WORD_W-1:0] word2;
    logic [WORD_W-1:0] word3;
    logic [WORD_W-1:0] word4;
    logic [WORD_W-1:0] word5;
    logic [WORD_W-1:0] word6;
    logic [WORD_W-1:0] word7;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] out_word0;
    logic [WORD_W-1:0] out_word1;
    logic [WORD_W-1:0] out_word2;
    logic [WORD_W-1:0] out_word3;
    logic [WORD_W-1:0] out_word4;
    logic [WORD_W-1:0] out_word5;
    logic [WORD_W-1:0] out_word6;
    logic [WORD_W-1:0] out_word7;
    logic [DEST_W-1:0] dest;
    logic              stream_end;
    logic              run_end;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/cbcr_in_if.sv @@
// ----------------------------------------------------------------------------
// command router input channel
// valid/ready channel carrying one 512-bit command word
// ----------------------------------------------------------------------------
`default_nettype none

interface cbcr_in_if;
  logic               valid;
  logic               ready;
  cbcr_pkg::in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ sv/cbcr_out_if.sv @@
// ----------------------------------------------------------------------------
// command router output channel
// valid/ready channel carrying one routed 512-bit word and its destination
// ----------------------------------------------------------------------------
`default_nettype none

interface cbcr_out_if;
  logic                valid;
  logic                ready;
  cbcr_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

@@ sv/cam_block_command_router.sv @@
// ----------------------------------------------------------------------------
// block command router
// decodes command words and routes them, with a destination mask, to a bank
// of content-addressable blocks selected through a table of table ids
// ----------------------------------------------------------------------------
//
//  channel  | modport | handshake    | payload
//  ---------+---------+--------------+---------------------------------------
//  in_i     | sink    | valid/ready  | word0..word7, last
//  out_o    | source  | valid/ready  | out_word0..out_word7, dest,
//           |         |              | stream_end, run_end
//
//  one input item is decoded per cycle: an input register feeds the decode,
//  whose one or two results land in a four-entry result queue
//  an item is decoded only when the queue has two free entries, so a stalled
//  output backs up into the input register and then into in_i.ready
//  items with one result stream at one per cycle, two-result commands are
//  bound by the output side, which drains the queue one result at a time
//  reset is asynchronous, active low, and clears the id table to all zero
//  after an end-of-stream marker every later item is taken and dropped
//
`default_nettype none

`include "cam_block_command_router_macros.svh"

module cam_block_command_router #(
  parameter int unsigned BLOCKS = 16
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  cbcr_in_if.sink   in_i,
  cbcr_out_if.source out_o
);

  localparam int unsigned LW  = cbcr_pkg::LANE_W;
  localparam int unsigned DW  = cbcr_pkg::DEST_W;
  localparam int unsigned PW  = cbcr_pkg::PTR_W;
  localparam int unsigned WLW = cbcr_pkg::WL_W;
  localparam int unsigned QW  = 32 - cbcr_pkg::ROW_BITS;

  // --------------------------------------------------------------------------
  // input register
  // --------------------------------------------------------------------------
  logic               in_valid_q;
  cbcr_pkg::in_item_t in_q;
  logic               fire;

  assign in_i.ready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.item;
    end
  end

  // --------------------------------------------------------------------------
  // router state
  // --------------------------------------------------------------------------
  cbcr_pkg::mode_e mode_q, mode_d;
  logic [LW-1:0]   table_q [BLOCKS];
  logic [LW-1:0]   table_d [BLOCKS];
  logic [PW-1:0]   ptr_q, ptr_d;
  logic [WLW-1:0]  wl_q, wl_d;
  logic [PW-1:0]   bl_q, bl_d;
  logic            halted_q, halted_d;

  // --------------------------------------------------------------------------
  // field extraction
  // --------------------------------------------------------------------------
  logic [cbcr_pkg::LINE_W-1:0] line_in;
  logic [31:0]                 op;
  logic [31:0]                 data;
  logic [31:0]                 off;
  logic [31:0]                 id;

  assign line_in = {in_q.word7, in_q.word6, in_q.word5, in_q.word4,
                    in_q.word3, in_q.word2, in_q.word1, in_q.word0};
  assign op   = in_q.word7[63:32];
  assign data = in_q.word0[31:0];
  assign off  = in_q.word0[63:32];
  assign id   = in_q.word1[31:0];

  // --------------------------------------------------------------------------
  // table lookup: match mask, first match, match count
  // --------------------------------------------------------------------------
  logic [BLOCKS-1:0] match;
  logic [PW-1:0]     first_idx;
  logic [PW-1:0]     match_cnt;

  always_comb begin
    match     = '0;
    first_idx = '0;
    match_cnt = '0;
    for (int i = 0; i < BLOCKS; i++) begin
      match[i] = (table_q[i] == id);
    end
    // scan downwards so the lowest matching block wins
    for (int i = BLOCKS - 1; i >= 0; i--) begin
      if (match[i]) begin
        first_idx = PW'(i);
      end
    end
    for (int i = 0; i < BLOCKS; i++) begin
      match_cnt = PW'(match_cnt + PW'(match[i]));
    end
  end

  logic [DW-1:0] match_dest;
  assign match_dest = DW'(match);

  // update-one target block: first match plus offset / rows per block
  logic [QW:0]   one_target;
  logic [DW-1:0] one_dest;

  assign one_target = (QW + 1)'(first_idx) + (QW + 1)'(off >> cbcr_pkg::ROW_BITS);
  assign one_dest   = (|match && one_target < (QW + 1)'(BLOCKS))
                      ? DW'(1) << one_target[3:0] : '0;

  // streaming target block
  logic [DW-1:0] ptr_dest;
  assign ptr_dest = (ptr_q < PW'(BLOCKS)) ? DW'(1) << ptr_q[3:0] : '0;

  // multi-query lanes: all-ones lanes drop out, the others pick their block
  logic [cbcr_pkg::LINE_W-1:0] mq_line;
  logic [DW-1:0]               mq_dest;

  always_comb begin
    mq_line = '0;
    mq_dest = '0;
    for (int i = 0; i < cbcr_pkg::LANES; i++) begin
      if (i < BLOCKS && line_in[LW*i +: LW] != cbcr_pkg::LANE_NONE) begin
        mq_line[LW*i +: LW] = line_in[LW*i +: LW];
        if (table_q[i] < LW'(BLOCKS)) begin
          mq_dest = mq_dest | (DW'(1) << table_q[i][3:0]);
        end
      end
    end
  end

  // streaming counters
  logic [WLW-1:0] wl_dec;
  logic [PW-1:0]  bl_dec;
  assign wl_dec = (wl_q != '0) ? WLW'(wl_q - WLW'(1)) : '0;
  assign bl_dec = (bl_q != '0) ? PW'(bl_q - PW'(1)) : '0;

  // --------------------------------------------------------------------------
  // decode
  // --------------------------------------------------------------------------
  function automatic cbcr_pkg::out_item_t make_item(
    input logic [cbcr_pkg::LINE_W-1:0] ln,
    input logic [DW-1:0]               dst,
    input logic                        se,
    input logic                        re
  );
    cbcr_pkg::out_item_t it;
    it.out_word0  = ln[63:0];
    it.out_word1  = ln[127:64];
    it.out_word2  = ln[191:128];
    it.out_word3  = ln[255:192];
    it.out_word4  = ln[319:256];
    it.out_word5  = ln[383:320];
    it.out_word6  = ln[447:384];
    it.out_word7  = ln[511:448];
    it.dest       = dst;
    it.stream_end = se;
    it.run_end    = re;
    return it;
  endfunction

  localparam logic [DW-1:0] DEST_ALL = DW'((17'd1 << BLOCKS) - 17'd1);

  cbcr_pkg::out_item_t res0, res1;
  logic [1:0]          push_n;

  always_comb begin
    mode_d   = mode_q;
    table_d  = table_q;
    ptr_d    = ptr_q;
    wl_d     = wl_q;
    bl_d     = bl_q;
    halted_d = halted_q;
    res0     = '0;
    res1     = '0;
    push_n   = 2'd0;
    if (fire && !halted_q) begin
      case (mode_q)
        cbcr_pkg::MODE_IDLE: begin
          if (in_q.last) begin
            // end of stream: one marker word to all blocks, then stop
            halted_d = 1'b1;
            res0     = make_item('0, DEST_ALL, 1'b1, 1'b1);
            push_n   = 2'd1;
          end else begin
            case (op)
              cbcr_pkg::OP_UPDATE_ONE: begin
                res0   = make_item({op, 480'b0}, one_dest, 1'b0, 1'b0);
                res1   = make_item({448'b0, 25'b0, off[cbcr_pkg::ROW_BITS-1:0], data},
                                   one_dest, 1'b0, 1'b1);
                push_n = 2'd2;
              end
              cbcr_pkg::OP_SEARCH_ONE: begin
                res0   = make_item({op, 32'd1, 448'b0}, match_dest, 1'b0, 1'b0);
                res1   = make_item({480'b0, data}, match_dest, 1'b0, 1'b1);
                push_n = 2'd2;
              end
              cbcr_pkg::OP_UPDATE_ALL: begin
                res0   = make_item({op, 480'b0}, DEST_ALL, 1'b0, 1'b1);
                push_n = 2'd1;
                mode_d = cbcr_pkg::MODE_TABLE;
              end
              cbcr_pkg::OP_SEARCH_MQ: begin
                res0   = make_item({op, 480'b0}, DEST_ALL, 1'b0, 1'b1);
                push_n = 2'd1;
                mode_d = cbcr_pkg::MODE_MQ;
              end
              cbcr_pkg::OP_UPDATE_GROUP: begin
                // no matching block leaves the router idle
                if (|match) begin
                  mode_d = cbcr_pkg::MODE_GROUP;
                  ptr_d  = first_idx;
                  bl_d   = match_cnt;
                  wl_d   = WLW'(cbcr_pkg::WORDS_PER_BLK);
                end
              end
              cbcr_pkg::OP_NOP: begin
                mode_d = cbcr_pkg::MODE_IDLE;
              end
              default: begin
                mode_d = cbcr_pkg::MODE_IDLE;
              end
            endcase
          end
        end
        cbcr_pkg::MODE_TABLE: begin
          for (int i = 0; i < BLOCKS; i++) begin
            table_d[i] = line_in[LW*i +: LW];
          end
          mode_d = cbcr_pkg::MODE_ALL;
          ptr_d  = '0;
          bl_d   = PW'(BLOCKS);
          wl_d   = WLW'(cbcr_pkg::WORDS_PER_BLK);
        end
        cbcr_pkg::MODE_ALL, cbcr_pkg::MODE_GROUP: begin
          res0   = make_item(line_in, ptr_dest, 1'b0, 1'b1);
          push_n = 2'd1;
          wl_d   = wl_dec;
          if (wl_dec == '0) begin
            ptr_d = PW'(ptr_q + PW'(1));
            wl_d  = WLW'(cbcr_pkg::WORDS_PER_BLK);
            bl_d  = bl_dec;
            if (bl_dec == '0) begin
              mode_d = cbcr_pkg::MODE_IDLE;
              wl_d   = '0;
            end
          end
        end
        cbcr_pkg::MODE_MQ: begin
          res0   = make_item(mq_line, mq_dest, 1'b0, 1'b1);
          push_n = 2'd1;
          mode_d = cbcr_pkg::MODE_IDLE;
        end
        default: begin
          mode_d = cbcr_pkg::MODE_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= cbcr_pkg::MODE_IDLE;
      ptr_q    <= '0;
      wl_q     <= '0;
      bl_q     <= '0;
      halted_q <= 1'b0;
      for (int i = 0; i < BLOCKS; i++) begin
        table_q[i] <= '0;
      end
    end else begin
      mode_q   <= mode_d;
      ptr_q    <= ptr_d;
      wl_q     <= wl_d;
      bl_q     <= bl_d;
      halted_q <= halted_d;
      table_q  <= table_d;
    end
  end

  // --------------------------------------------------------------------------
  // result queue
  // --------------------------------------------------------------------------
  cbcr_pkg::out_item_t              fifo_q [cbcr_pkg::FIFO_DEPTH];
  logic [cbcr_pkg::FIFO_PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [cbcr_pkg::FIFO_CNT_W-1:0]  cnt_q;
  logic                             pop;

  // decode only with room for the worst case of two results
  assign fire      = in_valid_q &&
                     (cnt_q <= cbcr_pkg::FIFO_CNT_W'(cbcr_pkg::FIFO_DEPTH - 2));
  assign out_o.valid = (cnt_q != '0);
  assign out_o.item  = fifo_q[rd_ptr_q];
  assign pop         = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= cbcr_pkg::FIFO_PTR_W'(wr_ptr_q + cbcr_pkg::FIFO_PTR_W'(push_n));
      rd_ptr_q <= cbcr_pkg::FIFO_PTR_W'(rd_ptr_q + cbcr_pkg::FIFO_PTR_W'(pop));
      cnt_q    <= cbcr_pkg::FIFO_CNT_W'(cnt_q + cbcr_pkg::FIFO_CNT_W'(push_n)
                                        - cbcr_pkg::FIFO_CNT_W'(pop));
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != 2'd0) begin
      fifo_q[wr_ptr_q] <= res0;
    end
    if (push_n == 2'd2) begin
      fifo_q[cbcr_pkg::FIFO_PTR_W'(wr_ptr_q + cbcr_pkg::FIFO_PTR_W'(1))] <= res1;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  `CBCR_ASSERT_SAME(a_queue_bound, clk_i, rst_ni, 1'b1,
                    cnt_q <= cbcr_pkg::FIFO_CNT_W'(cbcr_pkg::FIFO_DEPTH),
                    "result queue overflow")
  `CBCR_ASSERT_NEXT(a_halt_sticky, clk_i, rst_ni, halted_q, halted_q,
                    "router left halt without reset")
  `CBCR_ASSERT_NEXT(a_table_then_all, clk_i, rst_ni,
                    fire && !halted_q && mode_q == cbcr_pkg::MODE_TABLE,
                    mode_q == cbcr_pkg::MODE_ALL,
                    "table load did not start the update stream")
  `CBCR_ASSERT_SAME(a_end_only_halted, clk_i, rst_ni,
                    out_o.valid && out_o.item.stream_end, halted_q,
                    "stream end word without halt")

endmodule

`default_nettype wire
